// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bps_pkg.sv
package bps_pkg;

   // Widths fixed by the register map and the byte stream.
   localparam int BYTE_BITS     = 8;
   localparam int WORD_BITS     = 64;
   localparam int LEN_BITS      = 5;
   localparam int NEEDLE_BYTES  = 16;
   localparam int NEEDLE_IDX    = 4;
   localparam int CSR_IDX_BITS  = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_NEEDLE_LOW    = 2'd0,
      CSR_NEEDLE_HIGH   = 2'd1,
      CSR_NEEDLE_LENGTH = 2'd2
   } csr_index_type;

endpackage

// File: hw/rtl/bps_if.sv
// Haystack channel: one byte per beat, with a flag on the final byte.
interface bps_req_if;
   logic                          valid;
   logic                          ready;
   logic [bps_pkg::BYTE_BITS-1:0] hay_byte;
   logic                          last_byte;

   modport source (output valid, output hay_byte, output last_byte, input ready);
   modport sink (input valid, input hay_byte, input last_byte, output ready);
endinterface

// Result channel: one beat per finished search.
interface bps_rsp_if #(
   parameter int OFFSET_BITS = 32
);
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [OFFSET_BITS-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink (input valid, input found, input match_offset, output ready);
endinterface

// File: hw/rtl/byte_pattern_search.sv
// Channel   Direction  Beat contents
// req       in         hay_byte, last_byte
// rsp       out        found, match_offset
// csr       in         csr_we, csr_index, csr_data (write only)
//
// One haystack byte is taken every cycle unless req stalls; the compare across the row of
// window cells and the count check finish in the cycle the byte is taken.
// A result reaches rsp from the output register, by way of the skid entry while that one is held.
// Synchronous reset clears the count, the done flag, the needle registers and
// the result buffer; there is no clearing pass. req stalls only when two
// results are held, the output register and its skid entry both full.
`include "assert_macros.svh"

module byte_pattern_search #(
   parameter int NEEDLE_MAX  = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   bps_req_if.sink                          req,
   bps_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [bps_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [bps_pkg::WORD_BITS-1:0]    csr_data
);

   localparam logic [OFFSET_BITS-1:0] SEEN_MAX = '1;

   logic [bps_pkg::WORD_BITS-1:0]                         needle_low_ff;
   logic [bps_pkg::WORD_BITS-1:0]                         needle_high_ff;
   logic [bps_pkg::LEN_BITS-1:0]                          needle_len_ff;
   logic [bps_pkg::NEEDLE_BYTES-1:0][bps_pkg::BYTE_BITS-1:0] needle_bytes;
   logic [NEEDLE_MAX-1:0][bps_pkg::BYTE_BITS-1:0]         window;
   logic [NEEDLE_MAX-1:0]                                 hits;
   logic [OFFSET_BITS-1:0]                                seen_ff;
   logic [OFFSET_BITS-1:0]                                seen_in;
   logic [OFFSET_BITS-1:0]                                seen_next;
   logic [OFFSET_BITS-1:0]                                len_wide;
   logic                                                  done_ff;
   logic                                                  done_in;
   logic                                                  accept;
   logic                                                  active;
   logic                                                  len_ok;
   logic                                                  match;
   logic                                                  push;
   logic [OFFSET_BITS-1:0]                                push_offset;
   logic                                                  buf_full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         needle_len_ff  <= '0;
      end else if (csr_we) begin
         unique case (bps_pkg::csr_index_type'(csr_index))
            bps_pkg::CSR_NEEDLE_LOW: begin
               needle_low_ff <= csr_data;
            end
            bps_pkg::CSR_NEEDLE_HIGH: begin
               needle_high_ff <= csr_data;
            end
            bps_pkg::CSR_NEEDLE_LENGTH: begin
               needle_len_ff <= csr_data[bps_pkg::LEN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign needle_bytes = {needle_high_ff, needle_low_ff};

   // Handshake: a byte is taken unless both result entries are occupied.
   assign req.ready = !buf_full;
   assign accept    = req.valid && req.ready;
   assign active    = accept && !done_ff;

   // Row of window cells. Cell i checks the byte i places back from the incoming
   // one against needle byte length-1-i and takes that byte into its place on a shift.
   for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_cell
      logic [bps_pkg::LEN_BITS-1:0]  sel;
      logic [bps_pkg::BYTE_BITS-1:0] link;

      assign sel = needle_len_ff - bps_pkg::LEN_BITS'(i) - bps_pkg::LEN_BITS'(1);

      if (i == 0) begin : g_head
         assign link = req.hay_byte;
      end else begin : g_body
         assign link = window[i-1];
      end

      bps_cell u_cell (
         .clock       (clock),
         .shift       (active),
         .byte_in     (link),
         .needle_byte (needle_bytes[sel[bps_pkg::NEEDLE_IDX-1:0]]),
         .in_use      (bps_pkg::LEN_BITS'(i) < needle_len_ff),
         .byte_out    (window[i]),
         .hit         (hits[i])
      );
   end

   // Count with saturation, and the full-match decision on the new window.
   assign seen_next = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + OFFSET_BITS'(1);
   assign len_wide  = OFFSET_BITS'(needle_len_ff);
   assign len_ok    = (needle_len_ff != '0) &&
                      (needle_len_ff <= bps_pkg::LEN_BITS'(NEEDLE_MAX));
   assign match     = len_ok && (seen_next >= len_wide) && (&hits);

   assign push        = active && (match || req.last_byte);
   assign push_offset = match ? (seen_next - len_wide) : '0;

   // Search state: the final byte always restarts; a match mid-stream parks.
   always_comb begin
      seen_in = seen_ff;
      done_in = done_ff;
      if (accept) begin
         if (req.last_byte) begin
            seen_in = '0;
            done_in = 1'b0;
         end else if (!done_ff) begin
            seen_in = seen_next;
            done_in = match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         done_ff <= done_in;
      end
   end

   bps_out_buf #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_found  (match),
      .push_offset (push_offset),
      .full        (buf_full),
      .rsp         (rsp)
   );

   // A parked search gives no further result.
   `ASSERT_SAME(a_done_silent, clock, reset, done_ff, !push, "result after match")
   // A match before the final byte parks the search.
   `ASSERT_NEXT(a_match_parks, clock, reset, active && match && !req.last_byte, done_ff, "search not parked")
   // A not-found beat carries a zero offset.
   `ASSERT_SAME(a_miss_offset, clock, reset, rsp.valid && !rsp.found, rsp.match_offset == '0, "nonzero miss offset")

endmodule

// File: hw/rtl/bps_cell.sv
// One window position: holds a byte, passes it on when the window shifts and
// compares the byte arriving from its neighbour against its needle byte.
module bps_cell (
   input  logic                          clock,
   input  logic                          shift,
   input  logic [bps_pkg::BYTE_BITS-1:0] byte_in,
   input  logic [bps_pkg::BYTE_BITS-1:0] needle_byte,
   input  logic                          in_use,
   output logic [bps_pkg::BYTE_BITS-1:0] byte_out,
   output logic                          hit
);

   logic [bps_pkg::BYTE_BITS-1:0] window_ff;
   logic [bps_pkg::BYTE_BITS-1:0] window_in;

   // The byte takes its place in the window on every shift.
   assign window_in = shift ? byte_in : window_ff;

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   // Positions beyond the needle length always agree.
   assign hit      = !in_use || (byte_in == needle_byte);
   assign byte_out = window_ff;

endmodule

// File: hw/rtl/bps_out_buf.sv
`include "assert_macros.svh"

// Two-entry result buffer: an output register and a skid entry behind it, so
// that the search keeps taking bytes while one result waits downstream.
module bps_out_buf #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   push_found,
   input  logic [OFFSET_BITS-1:0] push_offset,
   output logic                   full,
   bps_rsp_if.source              rsp
);

   logic                   main_valid_ff;
   logic                   main_valid_in;
   logic                   main_found_ff;
   logic                   main_found_in;
   logic [OFFSET_BITS-1:0] main_offset_ff;
   logic [OFFSET_BITS-1:0] main_offset_in;
   logic                   skid_valid_ff;
   logic                   skid_valid_in;
   logic                   skid_found_ff;
   logic                   skid_found_in;
   logic [OFFSET_BITS-1:0] skid_offset_ff;
   logic [OFFSET_BITS-1:0] skid_offset_in;
   logic                   pop;

   assign pop = main_valid_ff && rsp.ready;

   // Next state of both entries. A push never arrives while the skid is full.
   always_comb begin
      main_valid_in  = main_valid_ff;
      main_found_in  = main_found_ff;
      main_offset_in = main_offset_ff;
      skid_valid_in  = skid_valid_ff;
      skid_found_in  = skid_found_ff;
      skid_offset_in = skid_offset_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_found_in  = skid_found_ff;
            main_offset_in = skid_offset_ff;
            skid_valid_in  = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_in  = 1'b1;
            main_found_in  = push_found;
            main_offset_in = push_offset;
         end else begin
            skid_valid_in  = 1'b1;
            skid_found_in  = push_found;
            skid_offset_in = push_offset;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_found_ff  <= main_found_in;
      main_offset_ff <= main_offset_in;
      skid_found_ff  <= skid_found_in;
      skid_offset_ff <= skid_offset_in;
   end

   assign full             = skid_valid_ff;
   assign rsp.valid        = main_valid_ff;
   assign rsp.found        = main_found_ff;
   assign rsp.match_offset = main_offset_ff;

   // The skid entry is only ever filled behind a waiting output beat.
   `ASSERT_SAME(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff, "skid without output")
   // A held skid entry moves to the output register when the output beat is taken.
   `ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && rsp.ready, !skid_valid_ff, "skid not drained")
   // An output beat that is not taken stays offered.
   `ASSERT_NEXT(a_out_held, clock, reset, rsp.valid && !rsp.ready, rsp.valid, "output beat dropped")

endmodule

// File: test/byte_pattern_search_test.sv
module byte_pattern_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OFFSET_BITS    = 32;
   localparam int RANDOM_BYTES   = 1700;
   localparam int MIN_PHASES     = 5;
   localparam int STALL_LIMIT    = 2000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 3;
   localparam int IDLE_PERCENT   = 12;

   typedef logic [bps_pkg::BYTE_BITS-1:0] byte_type;

   typedef struct packed {
      logic                   found;
      logic [OFFSET_BITS-1:0] match_offset;
   } search_outcome_type;

   // How a row of the directed table is checked.
   typedef enum int {
      OUT_PREDICTED,
      OUT_NONE,
      OUT_FOUND,
      OUT_MISSED
   } row_check_type;

   typedef struct {
      bit                            is_load;
      logic [bps_pkg::WORD_BITS-1:0] lo;
      logic [bps_pkg::WORD_BITS-1:0] hi;
      logic [bps_pkg::WORD_BITS-1:0] len_word;
      byte_type                      hay;
      bit                            last;
      row_check_type                 check;
      logic [OFFSET_BITS-1:0]        offset;
   } search_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   bps_pkg::csr_index_type        csr_index = bps_pkg::CSR_NEEDLE_LOW;
   logic [bps_pkg::WORD_BITS-1:0] csr_data = '0;

   bps_req_if req_ch ();
   bps_rsp_if #(.OFFSET_BITS(OFFSET_BITS)) rsp_ch ();

   byte_pattern_search #(
      .NEEDLE_MAX (bps_pkg::NEEDLE_BYTES),
      .OFFSET_BITS(OFFSET_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch.sink),
      .rsp      (rsp_ch.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #4 clock = ~clock;

   // Mirror of the search state and the needle registers.
   logic [bps_pkg::WORD_BITS-1:0] needle_lo_q;
   logic [bps_pkg::WORD_BITS-1:0] needle_hi_q;
   logic [bps_pkg::LEN_BITS-1:0]  needle_len_q;
   byte_type                      window_q [bps_pkg::NEEDLE_BYTES];
   logic [OFFSET_BITS-1:0]        seen_q;
   bit                            done_q;

   search_outcome_type awaited_outcomes[$];
   search_row_type     directed_rows[$];

   int  error_count = 0;
   int  sent_bytes = 0;
   int  live_bytes = 0;
   int  needle_loads = 0;
   int  matches_seen = 0;
   int  misses_seen = 0;
   int  idle_cycles = 0;
   int  req_idle_pct = IDLE_PERCENT;
   int  rsp_idle_pct = IDLE_PERCENT;
   bit  holdoff_request = 1'b0;

   function automatic byte_type needle_at(input int i);
      return (i < 8) ? needle_lo_q[8*i +: 8] : needle_hi_q[8*(i-8) +: 8];
   endfunction

   function automatic void restart_search();
      foreach (window_q[i]) window_q[i] = '0;
      seen_q = '0;
      done_q = 1'b0;
   endfunction

   function automatic bit window_holds_needle();
      int len;
      len = int'(needle_len_q);
      if (len == 0 || len > bps_pkg::NEEDLE_BYTES || seen_q < len) return 1'b0;
      // The newest byte sits at the front, so needle byte i is len-1-i back.
      for (int i = 0; i < len; i++) begin
         if (window_q[len-1-i] != needle_at(i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Advances the search by one haystack byte; returns 1 when a search ends.
   function automatic bit advance_search(input byte_type b, input bit last,
                                         output search_outcome_type outcome);
      outcome = '0;
      if (done_q) begin
         if (last) restart_search();
         return 1'b0;
      end
      for (int i = bps_pkg::NEEDLE_BYTES - 1; i > 0; i--) window_q[i] = window_q[i-1];
      window_q[0] = b;
      if (seen_q != '1) seen_q = seen_q + 1'b1;
      if (window_holds_needle()) begin
         outcome.found = 1'b1;
         outcome.match_offset = seen_q - OFFSET_BITS'(needle_len_q);
         if (last) restart_search();
         else done_q = 1'b1;
         return 1'b1;
      end
      if (last) begin
         restart_search();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Offers one haystack byte and records what it should produce once taken.
   task automatic send_beat(input byte_type b, input bit last, input row_check_type check,
                            input logic [OFFSET_BITS-1:0] typed_offset);
      search_outcome_type outcome;
      bit                 ends_search;
      bit                 was_live;
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.hay_byte  <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      was_live = !done_q;
      ends_search = advance_search(b, last, outcome);
      unique case (check)
         OUT_PREDICTED: begin
            if (ends_search) awaited_outcomes.push_back(outcome);
         end
         OUT_FOUND: begin
            outcome.found = 1'b1;
            outcome.match_offset = typed_offset;
            awaited_outcomes.push_back(outcome);
         end
         OUT_MISSED: begin
            outcome = '0;
            awaited_outcomes.push_back(outcome);
         end
         default: ;
      endcase
      sent_bytes++;
      if (was_live) live_bytes++;
   endtask

   // Stops offering and waits until every awaited result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_needle(input logic [bps_pkg::WORD_BITS-1:0] lo,
                              input logic [bps_pkg::WORD_BITS-1:0] hi,
                              input logic [bps_pkg::WORD_BITS-1:0] len_word);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= bps_pkg::CSR_NEEDLE_LOW;
      csr_data  <= lo;
      @(posedge clock);
      needle_lo_q = lo;
      csr_index <= bps_pkg::CSR_NEEDLE_HIGH;
      csr_data  <= hi;
      @(posedge clock);
      needle_hi_q = hi;
      csr_index <= bps_pkg::CSR_NEEDLE_LENGTH;
      csr_data  <= len_word;
      @(posedge clock);
      needle_len_q = len_word[bps_pkg::LEN_BITS-1:0];
      csr_we <= 1'b0;
      needle_loads++;
   endtask

   function automatic void add_load(input logic [bps_pkg::WORD_BITS-1:0] lo,
                                    input logic [bps_pkg::WORD_BITS-1:0] hi,
                                    input logic [bps_pkg::WORD_BITS-1:0] len_word);
      directed_rows.push_back('{1'b1, lo, hi, len_word, '0, 1'b0, OUT_NONE, '0});
   endfunction

   function automatic void add_beat(input byte_type b, input bit last,
                                    input row_check_type check,
                                    input logic [OFFSET_BITS-1:0] offset);
      directed_rows.push_back('{1'b0, '0, '0, '0, b, last, check, offset});
   endfunction

   // One needle setting followed by a handful of haystacks built around it.
   // A negative forced length or mode leaves the choice to chance.
   task automatic run_phase(input int force_len, input int force_mode, input bit calm,
                            input bit holdoff);
      byte_type                      needle_bytes [bps_pkg::NEEDLE_BYTES];
      byte_type                      hay[$];
      logic [bps_pkg::WORD_BITS-1:0] lo;
      logic [bps_pkg::WORD_BITS-1:0] hi;
      logic [bps_pkg::WORD_BITS-1:0] len_word;
      byte_type                      sym_a;
      byte_type                      sym_b;
      int                            len;
      int                            eff;
      int                            mode;
      int                            pick;
      int                            hlen;
      int                            pos;
      int                            haystacks;

      pick = $urandom_range(99);
      if (force_len >= 0) len = force_len;
      else if (pick < 5) len = 0;
      else if (pick < 10) len = $urandom_range(31, bps_pkg::NEEDLE_BYTES + 1);
      else if (pick < 25) len = 1;
      else if (pick < 40) len = bps_pkg::NEEDLE_BYTES;
      else len = $urandom_range(bps_pkg::NEEDLE_BYTES - 1, 2);
      eff = (len >= 1 && len <= bps_pkg::NEEDLE_BYTES) ? len : 0;

      // Needle content: random, a two-symbol alphabet for overlapping prefixes,
      // or all ones / all zeros.
      pick = $urandom_range(99);
      if (force_mode >= 0) mode = force_mode;
      else if (pick < 50) mode = 0;
      else if (pick < 85) mode = 1;
      else if (pick < 93) mode = 2;
      else mode = 3;
      sym_a = byte_type'($urandom_range(255));
      sym_b = byte_type'($urandom_range(255));
      foreach (needle_bytes[i]) begin
         unique case (mode)
            0: needle_bytes[i] = byte_type'($urandom_range(255));
            1: needle_bytes[i] = $urandom_range(1) ? sym_a : sym_b;
            2: needle_bytes[i] = 8'hFF;
            default: needle_bytes[i] = 8'h00;
         endcase
      end
      for (int i = 0; i < 8; i++) begin
         lo[8*i +: 8] = needle_bytes[i];
         hi[8*i +: 8] = needle_bytes[i+8];
      end
      len_word = bps_pkg::WORD_BITS'(len);
      if ($urandom_range(9) == 0) begin
         len_word = {$urandom, $urandom};
         len_word[bps_pkg::LEN_BITS-1:0] = bps_pkg::LEN_BITS'(len);
      end
      load_needle(lo, hi, len_word);

      req_idle_pct = calm ? 0 : IDLE_PERCENT;
      rsp_idle_pct = calm ? 0 : IDLE_PERCENT;

      // Single-byte haystacks pile up results while the receiver holds off.
      if (holdoff) begin
         holdoff_request = 1'b1;
         for (int k = 0; k < 60; k++) begin
            send_beat(($urandom_range(1) && eff > 0) ? needle_bytes[0]
                                                     : byte_type'($urandom_range(255)),
                      1'b1, OUT_PREDICTED, '0);
         end
         return;
      end

      haystacks = calm ? 10 : $urandom_range(8, 3);
      repeat (haystacks) begin
         hay.delete();
         hlen = $urandom_range(eff * 3 + 8, 1);
         if (calm) hlen += 30;
         if ($urandom_range(14) == 0) hlen = $urandom_range(150, 60);
         for (int i = 0; i < hlen; i++) begin
            if (eff > 0 && $urandom_range(1)) begin
               hay.push_back(needle_bytes[$urandom_range(eff - 1, 0)]);
            end else begin
               hay.push_back(byte_type'($urandom_range(255)));
            end
         end
         // Mostly plant the needle somewhere, sometimes with one bit spoilt.
         pick = $urandom_range(99);
         if (eff > 0 && hlen >= eff && pick < 75) begin
            pos = $urandom_range(hlen - eff, 0);
            for (int i = 0; i < eff; i++) hay[pos+i] = needle_bytes[i];
            if (pick >= 55) hay[pos + $urandom_range(eff - 1, 0)] ^= byte_type'(1 << $urandom_range(7));
         end
         foreach (hay[i]) send_beat(hay[i], i == hlen - 1, OUT_PREDICTED, '0);
      end
   endtask

   // Result side: random back-pressure, with a long hold-off on request.
   initial begin : result_receiver
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Each result beat is compared with the oldest awaited outcome.
   always @(posedge clock) begin : result_check
      search_outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_outcomes.size() == 0) begin
            $error("unexpected result beat: found=%0d match_offset=%0d",
                   rsp_ch.found, rsp_ch.match_offset);
            error_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_ch.found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
               error_count++;
            end
            if (rsp_ch.match_offset !== want.match_offset) begin
               $error("match_offset: expected %0d, actual %0d",
                      want.match_offset, rsp_ch.match_offset);
               error_count++;
            end
            if (want.found) matches_seen++;
            else misses_seen++;
         end
      end
   end

   // Ends the run when no beat has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int target;
      int phase;
      req_ch.valid     <= 1'b0;
      req_ch.hay_byte  <= '0;
      req_ch.last_byte <= 1'b0;
      needle_lo_q  = '0;
      needle_hi_q  = '0;
      needle_len_q = '0;
      restart_search();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset the needle is empty, so nothing can match.
      add_beat(8'h00, 1'b0, OUT_NONE, 0);
      add_beat(8'hFF, 1'b1, OUT_MISSED, 0);
      // Single-byte needle; later bytes of the same haystack are ignored.
      add_load(64'hFF, 64'h0, 64'd1);
      add_beat(8'h12, 1'b0, OUT_NONE, 0);
      add_beat(8'hFF, 1'b0, OUT_FOUND, 1);
      add_beat(8'hFF, 1'b0, OUT_NONE, 0);
      add_beat(8'h00, 1'b1, OUT_NONE, 0);
      // Match completing on the byte marked last.
      add_load(64'h434241, 64'h0, 64'd3);
      add_beat(8'h41, 1'b0, OUT_NONE, 0);
      add_beat(8'h42, 1'b0, OUT_NONE, 0);
      add_beat(8'h43, 1'b1, OUT_FOUND, 0);
      // Haystack shorter than the needle.
      add_beat(8'h41, 1'b0, OUT_NONE, 0);
      add_beat(8'h42, 1'b1, OUT_MISSED, 0);
      // Oversized lengths never match, even against agreeing bytes.
      add_load('1, '1, 64'd17);
      add_beat(8'hFF, 1'b1, OUT_MISSED, 0);
      add_load('1, '1, '1);
      add_beat(8'hFF, 1'b1, OUT_MISSED, 0);
      // Overlapping prefix: the match starts one byte in.
      add_load(64'h626161, 64'h0, 64'd3);
      add_beat(8'h61, 1'b0, OUT_NONE, 0);
      add_beat(8'h61, 1'b0, OUT_NONE, 0);
      add_beat(8'h61, 1'b0, OUT_NONE, 0);
      add_beat(8'h62, 1'b1, OUT_FOUND, 1);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_load) begin
            load_needle(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].len_word);
         end else begin
            send_beat(directed_rows[i].hay, directed_rows[i].last, directed_rows[i].check,
                      directed_rows[i].offset);
         end
      end

      // Random phases; the first two pin the longest needle, once all ones and once random,
      // and the hold-off phase always runs.
      target = sent_bytes + RANDOM_BYTES;
      phase = 0;
      while (sent_bytes < target || phase < MIN_PHASES) begin
         unique case (phase)
            0: run_phase(bps_pkg::NEEDLE_BYTES, 2, 1'b0, 1'b0);
            1: run_phase(bps_pkg::NEEDLE_BYTES, 0, 1'b0, 1'b0);
            2: run_phase(-1, -1, 1'b1, 1'b0);
            4: run_phase(1, -1, 1'b0, 1'b1);
            default: run_phase(-1, -1, 1'b0, 1'b0);
         endcase
         phase++;
      end

      wait_drained();
      $display("Sent %0d haystack bytes (%0d while a search was open) over %0d needle settings.",
               sent_bytes, live_bytes, needle_loads);
      $display("Results checked: %0d matches and %0d searches without a match.",
               matches_seen, misses_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
